@@ hw/rtl/ccb_pkg.sv @@
// Shared types, constants and helper functions for the click classifier
// and blink controller. Used by every module of the block; depends on nothing.
`default_nettype none

package ccb_pkg;

    // Field and timer widths
    localparam int CFG_BITS       = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int TIMER_BITS     = 16;
    localparam int PERIOD_COUNT   = 4;
    localparam int PTR_BITS       = 2;
    localparam int NUM_PERIODS    = 4;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAP        = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_BLINK = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TX_TIMEOUT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD_0   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD_1   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD_2   = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD_3   = 3'd7;

    // Reset values of the registers
    localparam logic [CFG_BITS-1:0] RST_DEBOUNCE   = 16'd70;
    localparam logic [CFG_BITS-1:0] RST_GAP        = 16'd200;
    localparam logic [CFG_BITS-1:0] RST_FAST_BLINK = 16'd100;
    localparam logic [CFG_BITS-1:0] RST_TX_TIMEOUT = 16'd3000;
    localparam logic [CFG_BITS-1:0] RST_PERIOD_0   = 16'd250;
    localparam logic [CFG_BITS-1:0] RST_PERIOD_1   = 16'd500;
    localparam logic [CFG_BITS-1:0] RST_PERIOD_2   = 16'd1000;
    localparam logic [CFG_BITS-1:0] RST_PERIOD_3   = 16'd2000;

    // Click report codes
    localparam logic [1:0] RPT_NONE   = 2'd0;
    localparam logic [1:0] RPT_SINGLE = 2'd1;
    localparam logic [1:0] RPT_DOUBLE = 2'd2;
    localparam logic [1:0] RPT_TRIPLE = 2'd3;

    // Button classifier phases
    typedef enum logic [3:0] {
        PH_IDLE         = 4'b0001,
        PH_DEBOUNCE     = 4'b0010,
        PH_WAIT_RELEASE = 4'b0100,
        PH_GAP          = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] debounce;
        logic [CFG_BITS-1:0] gap;
    } front_cfg_t;

    typedef struct packed {
        logic [CFG_BITS-1:0]                  fast_blink;
        logic [CFG_BITS-1:0]                  tx_timeout;
        logic [NUM_PERIODS-1:0][CFG_BITS-1:0] periods;
    } back_cfg_t;

    // One classified tick passed from front to back
    typedef struct packed {
        logic [1:0] report;
        logic       start;
        logic       stop;
    } cmd_t;

    // Clamp a register value to the timer range.
    function automatic logic [TIMER_BITS-1:0] lim(input logic [CFG_BITS-1:0] v);
        logic [CFG_BITS+TIMER_BITS-1:0] wide;
        wide = {{TIMER_BITS{1'b0}}, v};
        if (wide > {{CFG_BITS{1'b0}}, TMAX})
            return TMAX;
        return wide[TIMER_BITS-1:0];
    endfunction

    // Saturating increment of a timer.
    function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] t);
        if (t == TMAX)
            return TMAX;
        return t + TIMER_BITS'(1);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/click_classifier_blink_controller_top.sv @@
// Click classifier and LED blink controller, top level.
// Depends on ccb_pkg, ccb_cfg_regs, ccb_front, ccb_queue and ccb_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one word per millisecond tick with
//   button_level (0 pressed), tx_start and tx_end.
//   Output channel (out_valid / out_stall): one result word per tick word,
//   in order: led_level, period_select, tx_mode, radio_trigger and
//   status_changed.
//   Configuration channel (cfg_valid / cfg_ready): cfg_index selects one of
//   the eight 16-bit registers, cfg_data is the word written; cfg_ready is
//   always high. Write only while no tick word is in flight.
// An accepted tick word is written into the command queue; the back end then
// takes it from the queue head and registers its result word. Throughput is
// one word per cycle while the receiver does not stall.
// Reset clears the classifier, the command queue and the controller and
// loads the register defaults; no result is pending afterwards.
// While the receiver stalls the result word holds; the four-entry queue
// absorbs further tick words, then in_stall rises until space frees.
`default_nettype none

module click_classifier_blink_controller_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               button_level,
    input  wire logic                               tx_start,
    input  wire logic                               tx_end,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    led_level,
    output logic [ccb_pkg::PTR_BITS-1:0]            period_select,
    output logic                                    tx_mode,
    output logic                                    radio_trigger,
    output logic                                    status_changed,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ccb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [ccb_pkg::CFG_BITS-1:0]       cfg_data
);
    import ccb_pkg::*;

    front_cfg_t front_cfg;
    back_cfg_t  back_cfg;
    cmd_t       front_cmd;
    cmd_t       head_cmd;
    logic       q_full, q_empty, q_pop;
    logic       in_accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;

    // Register file
    ccb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cfg_valid && cfg_ready),
        .wr_index  (cfg_index),
        .wr_data   (cfg_data),
        .front_cfg (front_cfg),
        .back_cfg  (back_cfg)
    );

    // Classifier
    ccb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (front_cfg),
        .accept       (in_accept),
        .button_level (button_level),
        .tx_start     (tx_start),
        .tx_end       (tx_end),
        .cmd          (front_cmd)
    );

    // Command queue
    ccb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (front_cmd),
        .pop       (q_pop),
        .head      (head_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Blink controller
    ccb_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (back_cfg),
        .cmd            (head_cmd),
        .cmd_avail      (!q_empty),
        .cmd_pop        (q_pop),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .led_level      (led_level),
        .period_select  (period_select),
        .tx_mode        (tx_mode),
        .radio_trigger  (radio_trigger),
        .status_changed (status_changed)
    );

endmodule

`default_nettype wire

@@ hw/rtl/ccb_cfg_regs.sv @@
// Configuration register file of the click classifier and blink controller.
// Depends on ccb_pkg for register indexes, reset values and the config structs.
`default_nettype none

module ccb_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [ccb_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  wire logic [ccb_pkg::CFG_BITS-1:0]       wr_data,
    output ccb_pkg::front_cfg_t                     front_cfg,
    output ccb_pkg::back_cfg_t                      back_cfg
);
    import ccb_pkg::*;

    front_cfg_t front_reg;
    back_cfg_t  back_reg;

    // Register writes, one word per handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg.debounce  <= RST_DEBOUNCE;
            front_reg.gap       <= RST_GAP;
            back_reg.fast_blink <= RST_FAST_BLINK;
            back_reg.tx_timeout <= RST_TX_TIMEOUT;
            back_reg.periods[0] <= RST_PERIOD_0;
            back_reg.periods[1] <= RST_PERIOD_1;
            back_reg.periods[2] <= RST_PERIOD_2;
            back_reg.periods[3] <= RST_PERIOD_3;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DEBOUNCE:   front_reg.debounce  <= wr_data;
                REG_GAP:        front_reg.gap       <= wr_data;
                REG_FAST_BLINK: back_reg.fast_blink <= wr_data;
                REG_TX_TIMEOUT: back_reg.tx_timeout <= wr_data;
                REG_PERIOD_0:   back_reg.periods[0] <= wr_data;
                REG_PERIOD_1:   back_reg.periods[1] <= wr_data;
                REG_PERIOD_2:   back_reg.periods[2] <= wr_data;
                REG_PERIOD_3:   back_reg.periods[3] <= wr_data;
                default:        ;
            endcase
        end
    end

    assign front_cfg = front_reg;
    assign back_cfg  = back_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ccb_front.sv @@
// Front end: accepts tick words, runs the click classifier and emits commands.
// Depends on ccb_pkg for the phase type, report codes and timer helpers.
`default_nettype none

module ccb_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ccb_pkg::front_cfg_t cfg,
    input  wire logic                accept,
    input  wire logic                button_level,
    input  wire logic                tx_start,
    input  wire logic                tx_end,
    output ccb_pkg::cmd_t            cmd
);
    import ccb_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [1:0]            tally_reg, tally_next;
    logic [TIMER_BITS-1:0] timer_inc;
    logic [1:0]            report;
    logic                  pressed;

    assign pressed   = ~button_level;
    assign timer_inc = bump(timer_reg);

    // Classifier next state for the word on the input
    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        tally_next = tally_reg;
        report     = RPT_NONE;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    phase_next = PH_DEBOUNCE;
                    timer_next = '0;
                    tally_next = 2'd1;
                end
            end
            PH_DEBOUNCE:
            begin
                timer_next = timer_inc;
                if (timer_inc >= lim(cfg.debounce))
                    phase_next = PH_WAIT_RELEASE;
            end
            PH_WAIT_RELEASE:
            begin
                if (!pressed)
                begin
                    if (tally_reg == RPT_TRIPLE)
                    begin
                        report     = RPT_TRIPLE;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_GAP;
                        timer_next = '0;
                    end
                end
            end
            PH_GAP:
            begin
                if (pressed)
                begin
                    tally_next = tally_reg + 2'd1;
                    phase_next = PH_WAIT_RELEASE;
                end
                else
                begin
                    timer_next = timer_inc;
                    if (timer_inc >= lim(cfg.gap))
                    begin
                        report     = tally_reg;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // State update on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            tally_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            tally_reg <= tally_next;
        end
    end

    assign cmd.report = report;
    assign cmd.start  = tx_start;
    assign cmd.stop   = tx_end;

    // A report always returns the classifier to idle.
    a_report_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (report != RPT_NONE) |=> phase_reg == PH_IDLE)
        else $error("click report without return to idle");

    // Debounce only moves on to waiting for release.
    a_debounce_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == PH_DEBOUNCE)
        |=> (phase_reg == PH_DEBOUNCE) || (phase_reg == PH_WAIT_RELEASE))
        else $error("illegal exit from debounce");

    // A triple report only leaves the release wait with three clicks.
    a_triple_tally: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == PH_WAIT_RELEASE) && (report == RPT_TRIPLE)
        |-> tally_reg == RPT_TRIPLE)
        else $error("triple report with wrong tally");

endmodule

`default_nettype wire

@@ hw/rtl/ccb_queue.sv @@
// Short command queue between the classifier and the blink controller.
// Depends on ccb_pkg for the command type and queue depth.
`default_nettype none

module ccb_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ccb_pkg::cmd_t push_data,
    input  wire logic          pop,
    output ccb_pkg::cmd_t      head,
    output logic               full,
    output logic               empty
);
    import ccb_pkg::*;

    cmd_t                 mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_BITS'(1);
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            count_reg <= count_next;
        end
    end

    // The queue never overfills and is never read while empty.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && empty))
        else $error("queue overflow or underflow");

    // A lone push grows the count by one.
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + QCNT_BITS'(1))
        else $error("queue count did not follow a push");

    // A lone pop shrinks the count by one.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - QCNT_BITS'(1))
        else $error("queue count did not follow a pop");

endmodule

`default_nettype wire

@@ hw/rtl/ccb_back.sv @@
// Back end: applies click steps and transmit flags, runs the LED blink timer
// and holds the result word register. Depends on ccb_pkg.
`default_nettype none

module ccb_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ccb_pkg::back_cfg_t           cfg,
    input  wire ccb_pkg::cmd_t                cmd,
    input  wire logic                         cmd_avail,
    output logic                              cmd_pop,
    input  wire logic                         out_stall,
    output logic                              out_valid,
    output logic                              led_level,
    output logic [ccb_pkg::PTR_BITS-1:0]      period_select,
    output logic                              tx_mode,
    output logic                              radio_trigger,
    output logic                              status_changed
);
    import ccb_pkg::*;

    logic [PTR_BITS-1:0]   ptr_reg, ptr_next;
    logic                  led_reg, led_next;
    logic [TIMER_BITS-1:0] blink_reg, blink_next;
    logic                  tx_reg, tx_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                  trigger, changed;
    logic [TIMER_BITS-1:0] half;
    logic [TIMER_BITS-1:0] blink_inc;

    logic                  valid_reg;
    logic                  trig_reg, chg_reg;

    // Take a command whenever the result register is free or being emptied
    assign cmd_pop = cmd_avail && (!valid_reg || !out_stall);

    // Period step, transmit tracking and blink timer for one command
    always_comb
    begin
        ptr_next     = ptr_reg;
        tx_next      = tx_reg;
        elapsed_next = elapsed_reg;
        led_next     = led_reg;
        trigger      = 1'b0;
        changed      = 1'b0;

        unique case (cmd.report)
            RPT_SINGLE:
            begin
                ptr_next = (ptr_reg == PTR_BITS'(PERIOD_COUNT - 1)) ? '0
                                                                    : ptr_reg + PTR_BITS'(1);
                changed  = 1'b1;
            end
            RPT_DOUBLE:
            begin
                ptr_next = (ptr_reg == '0) ? PTR_BITS'(PERIOD_COUNT - 1)
                                           : ptr_reg - PTR_BITS'(1);
                changed  = 1'b1;
            end
            RPT_TRIPLE:
            begin
                trigger = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (cmd.start || cmd.stop)
        begin
            changed      = 1'b1;
            elapsed_next = '0;
            tx_next      = !cmd.stop;
        end
        else if (tx_reg)
        begin
            if (elapsed_reg >= lim(cfg.tx_timeout))
            begin
                tx_next = 1'b0;
                changed = 1'b1;
            end
            else
                elapsed_next = bump(elapsed_reg);
        end

        half       = lim(tx_next ? cfg.fast_blink : cfg.periods[ptr_next]);
        blink_inc  = bump(blink_reg);
        blink_next = blink_inc;
        if (blink_inc >= half)
        begin
            led_next   = !led_reg;
            blink_next = '0;
        end
    end

    // Controller state, advanced once per command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            led_reg     <= 1'b0;
            blink_reg   <= '0;
            tx_reg      <= 1'b0;
            elapsed_reg <= '0;
        end
        else if (cmd_pop)
        begin
            ptr_reg     <= ptr_next;
            led_reg     <= led_next;
            blink_reg   <= blink_next;
            tx_reg      <= tx_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd_pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            trig_reg <= trigger;
            chg_reg  <= changed;
        end
    end

    assign out_valid      = valid_reg;
    assign led_level      = led_reg;
    assign period_select  = ptr_reg;
    assign tx_mode        = tx_reg;
    assign radio_trigger  = trig_reg;
    assign status_changed = chg_reg;

    // A pending result is not overwritten while the receiver stalls.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_stall |-> !cmd_pop)
        else $error("result overwritten under stall");

    // Transmit end always leaves transmit mode off.
    a_end_clears_tx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && cmd.stop |=> !tx_reg)
        else $error("transmit still active after end");

    // A trigger word never carries a period step.
    a_trigger_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && (cmd.report == RPT_TRIPLE) |=> ptr_reg == $past(ptr_reg))
        else $error("period moved on a triple click");

endmodule

`default_nettype wire
